>>> hw/rtl/g3b_pkg.sv
`timescale 1ns / 1ps

package g3b_pkg;

  localparam int DEF_MAX_WIDTH  = 256;
  localparam int DEF_MAX_HEIGHT = 256;
  localparam int SAMPLE_BITS    = 16;
  localparam int OP_BITS        = 2;
  localparam int COORD_BITS     = 8;
  localparam int SIZE_BITS      = 9;
  localparam int CFG_IDX_BITS   = 3;
  localparam int CFG_DATA_BITS  = 9;

  // 40 times the largest sample fits in SUM_BITS.
  localparam int SUM_BITS   = SAMPLE_BITS + 6;
  localparam int RECIP_BITS = 19;
  localparam int DIV_SHIFT  = 21;
  // ceil(2^21 / 5); (sum >> 3) * RECIP >> 21 equals sum / 40 over the whole sum range.
  localparam logic [RECIP_BITS-1:0] DIV_RECIP = 19'd419431;

  localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

  localparam int TAP_BITS = 4;
  localparam logic [TAP_BITS-1:0] TAP_FIRST  = 4'd0;
  localparam logic [TAP_BITS-1:0] TAP_CENTER = 4'd4;
  localparam logic [TAP_BITS-1:0] TAP_LAST   = 4'd8;

  localparam int WEIGHT_BITS = 6;
  localparam logic [WEIGHT_BITS-1:0] W_CENTER = 6'd20;
  localparam logic [WEIGHT_BITS-1:0] W_EDGE   = 6'd4;
  localparam logic [WEIGHT_BITS-1:0] W_DIAG   = 6'd1;
  localparam logic [WEIGHT_BITS-1:0] W_PLAIN  = 6'd40;

  typedef enum logic [OP_BITS-1:0] {
    OP_WRITE = 2'd0,
    OP_READ  = 2'd1,
    OP_PASS  = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_GRID_W  = 3'd0,
    CFG_GRID_H  = 3'd1,
    CFG_AREA_XF = 3'd2,
    CFG_AREA_YF = 3'd3,
    CFG_AREA_XL = 3'd4,
    CFG_AREA_YL = 3'd5
  } cfg_reg_t;

  localparam logic REPLY_READ = 1'b0;
  localparam logic REPLY_DONE = 1'b1;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic done;
  } pass_ctl_t;

  // Taps run row by row over the 3x3 window; tap 4 is the center.
  function automatic logic [WEIGHT_BITS-1:0] tap_weight(input logic [TAP_BITS-1:0] k);
    logic [WEIGHT_BITS-1:0] w;
    unique case (k)
      4'd4:                   w = W_CENTER;
      4'd1, 4'd3, 4'd5, 4'd7: w = W_EDGE;
      default:                w = W_DIAG;
    endcase
    return w;
  endfunction

endpackage

>>> hw/rtl/grid_3x3_wrap_blur_engine_unit.sv
`timescale 1ns / 1ps
// Write item: written at start, no result. Read item: the sample passes the RAM read register
// and ST_READ before the result strobe. Blur pass: sweeps every one of MAX_WIDTH*MAX_HEIGHT
// points of the bank, nine taps through the single-port source RAM for a point inside the area
// and the center tap alone for a point that is only copied; the done result is strobed in the
// cycle after the last write. Synchronous active-low reset restores the register defaults and
// bank 0; grid contents are undefined until written. Results cannot be stalled by the receiver.

module grid_3x3_wrap_blur_engine_unit #(
  parameter int MAX_WIDTH  = g3b_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = g3b_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [g3b_pkg::OP_BITS-1:0]          in_opcode,
  input  logic [g3b_pkg::COORD_BITS-1:0]       in_col,
  input  logic [g3b_pkg::COORD_BITS-1:0]       in_row,
  input  logic [g3b_pkg::SAMPLE_BITS-1:0]      in_sample_in,
  output logic                                 out_strobe,
  output logic                                 out_reply_kind,
  output logic [g3b_pkg::SAMPLE_BITS-1:0]      out_sample_out,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [g3b_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [g3b_pkg::CFG_DATA_BITS-1:0]    cfg_data
);
  import g3b_pkg::*;

  localparam int XW    = $clog2(MAX_WIDTH);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_READ = 3'b010,
    ST_PASS = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic                   bank_r, bank_nxt;
  logic [SIZE_BITS-1:0]   grid_w_r, grid_h_r;
  logic [COORD_BITS-1:0]  axf_r, ayf_r, axl_r, ayl_r;
  logic                   strobe_r, strobe_nxt, kind_r, kind_nxt;
  logic [SAMPLE_BITS-1:0] sample_r, sample_nxt;

  logic [XW:0]            w_eff;
  logic [YW:0]            h_eff;
  logic [XW-1:0]          x_lim, col_c, xl_c, xf_c;
  logic [YW-1:0]          y_lim, row_c, yl_c, yf_c;
  logic                   area_ok, item_acc, item_wr, item_rd, pass_go;
  logic [AW-1:0]          item_addr;

  pass_ctl_t              pctl;
  logic [AW-1:0]          p_rd_addr, p_wr_addr;
  logic [SAMPLE_BITS-1:0] p_wr_data;

  logic                   ram_en [2];
  logic                   ram_we [2];
  logic [AW-1:0]          ram_addr [2];
  logic [SAMPLE_BITS-1:0] ram_wd [2];
  logic [SAMPLE_BITS-1:0] ram_rd [2];

  // Grid size in use: zero counts as one, anything past the maximum as the maximum.
  always_comb begin
    if (grid_w_r == '0) begin
      w_eff = (XW+1)'(1);
    end else if (32'(grid_w_r) > MAX_WIDTH) begin
      w_eff = (XW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (XW+1)'(grid_w_r);
    end
    if (grid_h_r == '0) begin
      h_eff = (YW+1)'(1);
    end else if (32'(grid_h_r) > MAX_HEIGHT) begin
      h_eff = (YW+1)'(MAX_HEIGHT);
    end else begin
      h_eff = (YW+1)'(grid_h_r);
    end
  end

  assign x_lim = XW'(w_eff - 1'b1);
  assign y_lim = YW'(h_eff - 1'b1);
  assign col_c = (32'(in_col) > 32'(x_lim)) ? x_lim : XW'(in_col);
  assign row_c = (32'(in_row) > 32'(y_lim)) ? y_lim : YW'(in_row);
  assign xl_c  = (32'(axl_r) > 32'(x_lim)) ? x_lim : XW'(axl_r);
  assign yl_c  = (32'(ayl_r) > 32'(y_lim)) ? y_lim : YW'(ayl_r);
  assign xf_c  = XW'(axf_r);
  assign yf_c  = YW'(ayf_r);
  // An area whose first bound lies past its last bound is empty.
  assign area_ok = (32'(axf_r) <= 32'(xl_c)) && (32'(ayf_r) <= 32'(yl_c));

  assign busy      = (state_r != ST_IDLE);
  assign cfg_ready = ~busy;
  assign item_acc  = start && !busy;
  assign item_wr   = item_acc && (in_opcode == OP_WRITE);
  assign item_rd   = item_acc && (in_opcode == OP_READ);
  assign pass_go   = item_acc && (in_opcode == OP_PASS);
  assign item_addr = AW'(32'(row_c) * MAX_WIDTH + 32'(col_c));

  for (genvar b = 0; b < 2; b++) begin : g_bank
    always_comb begin
      ram_en[b]   = 1'b0;
      ram_we[b]   = 1'b0;
      ram_addr[b] = item_addr;
      ram_wd[b]   = in_sample_in;
      if (state_r == ST_PASS) begin
        if (1'(b) == bank_r) begin
          ram_en[b]   = pctl.rd_en;
          ram_addr[b] = p_rd_addr;
        end else begin
          ram_en[b]   = pctl.wr_en;
          ram_we[b]   = pctl.wr_en;
          ram_addr[b] = p_wr_addr;
          ram_wd[b]   = p_wr_data;
        end
      end else if (1'(b) == bank_r) begin
        ram_en[b] = item_wr || item_rd;
        ram_we[b] = item_wr;
      end
    end

    g3b_ram #(
      .WIDTH (SAMPLE_BITS),
      .DEPTH (DEPTH)
    ) u_ram (
      .clk   (clk),
      .en    (ram_en[b]),
      .we    (ram_we[b]),
      .addr  (ram_addr[b]),
      .wdata (ram_wd[b]),
      .rdata (ram_rd[b])
    );
  end

  g3b_pass #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_pass (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (pass_go),
    .w_eff   (w_eff),
    .h_eff   (h_eff),
    .x_first (xf_c),
    .x_last  (xl_c),
    .y_first (yf_c),
    .y_last  (yl_c),
    .area_ok (area_ok),
    .rd_data (ram_rd[bank_r]),
    .ctl     (pctl),
    .rd_addr (p_rd_addr),
    .wr_addr (p_wr_addr),
    .wr_data (p_wr_data)
  );

  always_comb begin
    state_nxt  = state_r;
    bank_nxt   = bank_r;
    strobe_nxt = 1'b0;
    kind_nxt   = kind_r;
    sample_nxt = sample_r;
    unique case (state_r)
      ST_IDLE: begin
        if (item_rd) begin
          state_nxt = ST_READ;
        end else if (pass_go) begin
          state_nxt = ST_PASS;
        end
      end
      ST_READ: begin
        strobe_nxt = 1'b1;
        kind_nxt   = REPLY_READ;
        sample_nxt = ram_rd[bank_r];
        state_nxt  = ST_IDLE;
      end
      ST_PASS: begin
        if (pctl.done) begin
          strobe_nxt = 1'b1;
          kind_nxt   = REPLY_DONE;
          sample_nxt = '0;
          bank_nxt   = ~bank_r;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      bank_r   <= 1'b0;
      strobe_r <= 1'b0;
      grid_w_r <= SIZE_BITS'(256);
      grid_h_r <= SIZE_BITS'(256);
      axf_r    <= '0;
      ayf_r    <= '0;
      axl_r    <= '1;
      ayl_r    <= '1;
    end else begin
      state_r  <= state_nxt;
      bank_r   <= bank_nxt;
      strobe_r <= strobe_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_GRID_W:  grid_w_r <= cfg_data;
          CFG_GRID_H:  grid_h_r <= cfg_data;
          CFG_AREA_XF: axf_r    <= cfg_data[COORD_BITS-1:0];
          CFG_AREA_YF: ayf_r    <= cfg_data[COORD_BITS-1:0];
          CFG_AREA_XL: axl_r    <= cfg_data[COORD_BITS-1:0];
          CFG_AREA_YL: ayl_r    <= cfg_data[COORD_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    sample_r <= sample_nxt;
  end

  assign out_strobe     = strobe_r;
  assign out_reply_kind = kind_r;
  assign out_sample_out = sample_r;

  a_bank_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    (bank_r != $past(bank_r)) |-> $past(pctl.done))
    else $error("bank switched without a finished pass");

  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    strobe_r |-> ($past(state_r == ST_READ) || $past(pctl.done)))
    else $error("result strobed without a read or a finished pass");

  a_pass_no_item: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PASS) |-> !(item_wr || item_rd))
    else $error("item grid access during a pass");

endmodule

>>> hw/rtl/g3b_ram.sv
`timescale 1ns / 1ps

module g3b_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata_r <= mem[addr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/g3b_pass.sv
`timescale 1ns / 1ps

module g3b_pass #(
  parameter int MAX_WIDTH  = g3b_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = g3b_pkg::DEF_MAX_HEIGHT
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   go,
  input  logic [$clog2(MAX_WIDTH):0]             w_eff,
  input  logic [$clog2(MAX_HEIGHT):0]            h_eff,
  input  logic [$clog2(MAX_WIDTH)-1:0]           x_first,
  input  logic [$clog2(MAX_WIDTH)-1:0]           x_last,
  input  logic [$clog2(MAX_HEIGHT)-1:0]          y_first,
  input  logic [$clog2(MAX_HEIGHT)-1:0]          y_last,
  input  logic                                   area_ok,
  input  logic [g3b_pkg::SAMPLE_BITS-1:0]        rd_data,
  output g3b_pkg::pass_ctl_t                     ctl,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] rd_addr,
  output logic [$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0] wr_addr,
  output logic [g3b_pkg::SAMPLE_BITS-1:0]        wr_data
);
  import g3b_pkg::*;

  localparam int XW = $clog2(MAX_WIDTH);
  localparam int YW = $clog2(MAX_HEIGHT);
  localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);
  localparam int PW = SUM_BITS - 3 + RECIP_BITS;
  localparam int QW = SAMPLE_BITS + 1;

  typedef enum logic [5:0] {
    P_IDLE  = 6'b000001,
    P_LOAD  = 6'b000010,
    P_TAP   = 6'b000100,
    P_DRAIN = 6'b001000,
    P_MUL   = 6'b010000,
    P_WR    = 6'b100000
  } pstate_t;

  pstate_t               state_r, state_nxt;
  logic [XW-1:0]         px_r, px_nxt;
  logic [YW-1:0]         py_r, py_nxt;
  logic [TAP_BITS-1:0]   tap_r, tap_nxt, pend_tap_r, pend_tap_nxt;
  logic                  pend_r, pend_nxt;
  logic                  inarea_r, inarea_nxt;
  logic [SUM_BITS-1:0]   acc_r, acc_nxt, acc_add;
  logic [QW-1:0]         q_r, q_nxt;
  logic [PW-1:0]         prod;
  logic [WEIGHT_BITS-1:0] wgt;
  logic                  in_area, last_pt;
  logic [XW-1:0]         xm, xp, tx;
  logic [YW-1:0]         ym, yp, ty;

  assign in_area = area_ok && (px_r >= x_first) && (px_r <= x_last)
                   && (py_r >= y_first) && (py_r <= y_last);
  assign last_pt = (32'(px_r) == MAX_WIDTH - 1) && (32'(py_r) == MAX_HEIGHT - 1);

  // Toroidal neighbors inside the grid in use.
  assign xm = (px_r == '0) ? XW'(w_eff - 1'b1) : px_r - 1'b1;
  assign xp = (32'(px_r) + 1 == 32'(w_eff)) ? '0 : px_r + 1'b1;
  assign ym = (py_r == '0) ? YW'(h_eff - 1'b1) : py_r - 1'b1;
  assign yp = (32'(py_r) + 1 == 32'(h_eff)) ? '0 : py_r + 1'b1;

  always_comb begin
    unique case (tap_r)
      4'd0, 4'd3, 4'd6: tx = xm;
      4'd2, 4'd5, 4'd8: tx = xp;
      default:          tx = px_r;
    endcase
    unique case (tap_r)
      4'd0, 4'd1, 4'd2: ty = ym;
      4'd6, 4'd7, 4'd8: ty = yp;
      default:          ty = py_r;
    endcase
  end

  assign rd_addr = AW'(32'(ty) * MAX_WIDTH + 32'(tx));
  assign wr_addr = AW'(32'(py_r) * MAX_WIDTH + 32'(px_r));
  assign wr_data = (q_r > QW'(SAMPLE_MAX)) ? SAMPLE_MAX : SAMPLE_BITS'(q_r);

  assign wgt     = inarea_r ? tap_weight(pend_tap_r) : W_PLAIN;
  assign acc_add = acc_r + SUM_BITS'(wgt) * SUM_BITS'(rd_data);
  assign prod    = PW'(acc_r >> 3) * PW'(DIV_RECIP);

  always_comb begin
    state_nxt    = state_r;
    px_nxt       = px_r;
    py_nxt       = py_r;
    tap_nxt      = tap_r;
    pend_nxt     = 1'b0;
    pend_tap_nxt = pend_tap_r;
    inarea_nxt   = inarea_r;
    acc_nxt      = acc_r;
    q_nxt        = q_r;
    ctl          = '0;
    unique case (state_r)
      P_IDLE: begin
        if (go) begin
          px_nxt    = '0;
          py_nxt    = '0;
          state_nxt = P_LOAD;
        end
      end
      P_LOAD: begin
        acc_nxt    = '0;
        inarea_nxt = in_area;
        tap_nxt    = in_area ? TAP_FIRST : TAP_CENTER;
        state_nxt  = P_TAP;
      end
      P_TAP: begin
        ctl.rd_en    = 1'b1;
        pend_nxt     = 1'b1;
        pend_tap_nxt = tap_r;
        if (pend_r) begin
          acc_nxt = acc_add;
        end
        if (tap_r == (inarea_r ? TAP_LAST : TAP_CENTER)) begin
          state_nxt = P_DRAIN;
        end else begin
          tap_nxt = tap_r + 1'b1;
        end
      end
      P_DRAIN: begin
        acc_nxt   = acc_add;
        state_nxt = P_MUL;
      end
      P_MUL: begin
        q_nxt     = QW'(prod >> DIV_SHIFT);
        state_nxt = P_WR;
      end
      P_WR: begin
        ctl.wr_en = 1'b1;
        if (last_pt) begin
          ctl.done  = 1'b1;
          state_nxt = P_IDLE;
        end else begin
          if (32'(px_r) == MAX_WIDTH - 1) begin
            px_nxt = '0;
            py_nxt = py_r + 1'b1;
          end else begin
            px_nxt = px_r + 1'b1;
          end
          state_nxt = P_LOAD;
        end
      end
      default: state_nxt = P_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= P_IDLE;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    tap_r      <= tap_nxt;
    pend_tap_r <= pend_tap_nxt;
    inarea_r   <= inarea_nxt;
    acc_r      <= acc_nxt;
    q_r        <= q_nxt;
  end

  a_drain_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == P_DRAIN) |-> pend_r)
    else $error("drain without a read in flight");

  a_pend_from_tap: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> $past(state_r == P_TAP))
    else $error("read data expected without a tap read");

  a_write_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.wr_en |-> $past(state_r == P_MUL))
    else $error("point written before its quotient was ready");

endmodule
